FILE: design/s8d_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and constants for the stick to eight-way pad block.
package s8d_pkg;

   localparam int AXIS_FULL_SCALE = 32767;
   localparam int QUEUE_DEPTH     = 2;

   localparam int AXIS_W = 16;
   localparam int MAG_W  = 15;
   localparam int KEYS_W = 16;
   localparam int CFG_W  = 15;
   localparam int IDX_W  = 2;
   localparam int PROD_W = 2 * MAG_W;

   // register indexes
   localparam logic [IDX_W-1:0] CSR_MODE     = 2'd0;
   localparam logic [IDX_W-1:0] CSR_DEADZONE = 2'd1;
   localparam logic [IDX_W-1:0] CSR_WALK     = 2'd2;

   // mode codes
   localparam logic [1:0] MODE_PASS    = 2'd0;
   localparam logic [1:0] MODE_RUN     = 2'd1;
   localparam logic [1:0] MODE_WALKRUN = 2'd2;

   localparam logic [CFG_W-1:0] DZ_MIN   = 15'd1638;
   localparam logic [CFG_W-1:0] DZ_MAX   = 15'd16384;
   localparam logic [CFG_W-1:0] DZ_RESET = 15'd4915;
   localparam logic [CFG_W-1:0] WT_RESET = 15'd22937;

   // tan(22.5 deg) in Q0.16
   localparam logic [MAG_W-1:0] TAN_SECTOR_Q16 = 15'd27146;

   localparam logic [KEYS_W-1:0] DIR_MASK  = 16'h00F0;
   localparam logic [KEYS_W-1:0] KEY_RIGHT = 16'h0010;
   localparam logic [KEYS_W-1:0] KEY_LEFT  = 16'h0020;
   localparam logic [KEYS_W-1:0] KEY_UP    = 16'h0040;
   localparam logic [KEYS_W-1:0] KEY_DOWN  = 16'h0080;

   typedef struct packed {
      logic [MAG_W-1:0]  mag_x;
      logic [MAG_W-1:0]  mag_y;
      logic              x_pos;
      logic              y_pos;
      logic [KEYS_W-1:0] keys;
      logic              analog;
      logic              walk;
   } item_type;

   typedef struct packed {
      logic [KEYS_W-1:0] keys_out;
      logic              in_deadzone;
      logic              walk_skipped;
   } result_type;

endpackage

FILE: design/s8d_channels.sv
`timescale 1ns / 1ps
// Handshake channel interfaces: stick samples in, key words out, register writes.
interface s8d_req_if;
   logic                                  valid;
   logic                                  ready;
   logic signed [s8d_pkg::AXIS_W-1:0]     stick_x;
   logic signed [s8d_pkg::AXIS_W-1:0]     stick_y;
   logic        [s8d_pkg::KEYS_W-1:0]     keys_in;
   modport source (output valid, stick_x, stick_y, keys_in, input ready);
   modport sink   (input valid, stick_x, stick_y, keys_in, output ready);
endinterface

interface s8d_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [s8d_pkg::KEYS_W-1:0]     keys_out;
   logic                           in_deadzone;
   logic                           walk_skipped;
   modport source (output valid, keys_out, in_deadzone, walk_skipped, input ready);
   modport sink   (input valid, keys_out, in_deadzone, walk_skipped, output ready);
endinterface

interface s8d_csr_if;
   logic                          valid;
   logic                          ready;
   logic [s8d_pkg::IDX_W-1:0]     index;
   logic [s8d_pkg::CFG_W-1:0]     data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

FILE: design/s8d_front.sv
`timescale 1ns / 1ps
// Front classifier: clamp axes, split sign and magnitude, tag the mode.
module s8d_front #(
   parameter int AXIS_FULL_SCALE = s8d_pkg::AXIS_FULL_SCALE
) (
   input  logic signed [s8d_pkg::AXIS_W-1:0] stick_x,
   input  logic signed [s8d_pkg::AXIS_W-1:0] stick_y,
   input  logic        [s8d_pkg::KEYS_W-1:0] keys_in,
   input  logic        [1:0]                 mode,
   output s8d_pkg::item_type                 item
);

   localparam int EXT_W = s8d_pkg::AXIS_W + 1;
   localparam logic signed [EXT_W-1:0] POS_LIM = EXT_W'(AXIS_FULL_SCALE);
   localparam logic signed [EXT_W-1:0] NEG_LIM = -POS_LIM;

   logic signed [EXT_W-1:0] x_ext, y_ext, x_clip, y_clip, x_abs, y_abs;

   always_comb begin
      x_ext = {stick_x[s8d_pkg::AXIS_W-1], stick_x};
      y_ext = {stick_y[s8d_pkg::AXIS_W-1], stick_y};

      priority if (x_ext > POS_LIM) x_clip = POS_LIM;
      else if (x_ext < NEG_LIM)     x_clip = NEG_LIM;
      else                          x_clip = x_ext;

      priority if (y_ext > POS_LIM) y_clip = POS_LIM;
      else if (y_ext < NEG_LIM)     y_clip = NEG_LIM;
      else                          y_clip = y_ext;

      x_abs = x_clip[EXT_W-1] ? -x_clip : x_clip;
      y_abs = y_clip[EXT_W-1] ? -y_clip : y_clip;

      item.mag_x  = x_abs[s8d_pkg::MAG_W-1:0];
      item.mag_y  = y_abs[s8d_pkg::MAG_W-1:0];
      // strictly positive: sign clear and not zero
      item.x_pos  = !x_clip[EXT_W-1] && (x_clip != '0);
      item.y_pos  = !y_clip[EXT_W-1] && (y_clip != '0);
      item.keys   = keys_in;
      item.analog = (mode == s8d_pkg::MODE_RUN) || (mode == s8d_pkg::MODE_WALKRUN);
      item.walk   = (mode == s8d_pkg::MODE_WALKRUN);
   end

endmodule

FILE: design/s8d_queue.sv
`timescale 1ns / 1ps
// Small register queue between the front classifier and the back datapath.
module s8d_queue #(
   parameter int DEPTH = s8d_pkg::QUEUE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  s8d_pkg::item_type push_item,
   output logic              full,
   input  logic              pop,
   output logic              not_empty,
   output s8d_pkg::item_type pop_item
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

   s8d_pkg::item_type slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign pop_item  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

FILE: design/s8d_back.sv
`timescale 1ns / 1ps
// Back datapath: square and tangent products, then deadzone, walk and sector decision.
module s8d_back (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       q_valid,
   input  s8d_pkg::item_type          q_item,
   output logic                       q_pop,
   input  logic [s8d_pkg::CFG_W-1:0]  deadzone,
   input  logic [s8d_pkg::CFG_W-1:0]  walk_thresh,
   input  logic                       out_ready,
   output logic                       out_valid,
   output s8d_pkg::result_type        out_result
);

   localparam int PW = s8d_pkg::PROD_W;

   logic s1_v_ff, out_v_ff, parity_ff, parity_in;
   logic s1_en, out_en;
   s8d_pkg::item_type   s1_item_ff;
   s8d_pkg::result_type out_ff, out_in;
   logic [PW-1:0] ax2_ff, ay2_ff, tx_ff, ty_ff, dz2_ff, wt2_ff;
   logic [PW:0]   mag2;
   logic [s8d_pkg::KEYS_W-1:0] press;
   logic dz_hit, wt_hit, horiz, vert, par_next;

   assign out_en     = !out_v_ff || out_ready;
   assign s1_en      = !s1_v_ff || out_en;
   assign q_pop      = q_valid && s1_en;
   assign out_valid  = out_v_ff;
   assign out_result = out_ff;

   always_comb begin
      mag2     = {1'b0, ax2_ff} + {1'b0, ay2_ff};
      dz_hit   = mag2 < {1'b0, dz2_ff};
      wt_hit   = mag2 < {1'b0, wt2_ff};
      horiz    = {s1_item_ff.mag_y, 16'b0} < {1'b0, tx_ff};
      vert     = {s1_item_ff.mag_x, 16'b0} < {1'b0, ty_ff};
      par_next = ~parity_ff;
      press    = '0;
      if (!vert) begin
         press = press | (s1_item_ff.x_pos ? s8d_pkg::KEY_RIGHT : s8d_pkg::KEY_LEFT);
      end
      if (!horiz) begin
         press = press | (s1_item_ff.y_pos ? s8d_pkg::KEY_DOWN : s8d_pkg::KEY_UP);
      end

      parity_in           = parity_ff;
      out_in.keys_out     = s1_item_ff.keys;
      out_in.in_deadzone  = 1'b0;
      out_in.walk_skipped = 1'b0;
      priority if (!s1_item_ff.analog) begin
         // pass-through: hold parity
      end else if (dz_hit) begin
         out_in.in_deadzone = 1'b1;
      end else begin
         parity_in = par_next;
         if (s1_item_ff.walk && wt_hit && par_next) begin
            out_in.walk_skipped = 1'b1;
         end else begin
            out_in.keys_out = (s1_item_ff.keys | s8d_pkg::DIR_MASK) & ~press;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff   <= 1'b0;
         out_v_ff  <= 1'b0;
         parity_ff <= 1'b0;
      end else begin
         if (s1_en) begin
            s1_v_ff <= q_valid;
         end
         if (out_en) begin
            out_v_ff <= s1_v_ff;
         end
         if (s1_v_ff && out_en) begin
            parity_ff <= parity_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      dz2_ff <= PW'(deadzone) * PW'(deadzone);
      wt2_ff <= PW'(walk_thresh) * PW'(walk_thresh);
      if (q_pop) begin
         s1_item_ff <= q_item;
         ax2_ff     <= PW'(q_item.mag_x) * PW'(q_item.mag_x);
         ay2_ff     <= PW'(q_item.mag_y) * PW'(q_item.mag_y);
         tx_ff      <= PW'(s8d_pkg::TAN_SECTOR_Q16) * PW'(q_item.mag_x);
         ty_ff      <= PW'(s8d_pkg::TAN_SECTOR_Q16) * PW'(q_item.mag_y);
      end
      if (s1_v_ff && out_en) begin
         out_ff <= out_in;
      end
   end

endmodule

FILE: design/stick_to_eight_way_dpad.sv
`timescale 1ns / 1ps
// Top level: analog stick sample to eight-way active-low direction keys.
//
// Each stick item (signed X, Y and an active-low key word) is clamped to
// +-AXIS_FULL_SCALE, classified and queued by the front, then the back squares
// both axes, compares the squared radius with the squared deadzone and walk
// radius, and picks one of eight 45-degree sectors with fixed-point tan(22.5)
// compares; Y positive means down. The block takes one item per cycle while
// the queue has room; each result passes through the queue and the
// multiplier stage, after which it sits in the output register. The walk
// parity bit flips in the output stage, so items are decided strictly in
// order. The queue (QUEUE_DEPTH entries) plus the two back stages absorb
// output stalls; req.ready drops only when the queue fills.
// Register writes are accepted on every cycle (csr.ready is tied high) and
// must land only while no item is in flight. A deadzone write saturates to
// 1638..16384; index 3 is ignored.
module stick_to_eight_way_dpad #(
   parameter int AXIS_FULL_SCALE = s8d_pkg::AXIS_FULL_SCALE,
   parameter int QUEUE_DEPTH     = s8d_pkg::QUEUE_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   s8d_req_if.sink    req,
   s8d_rsp_if.source  rsp,
   s8d_csr_if.sink    csr
);

   // configuration registers
   logic [1:0]                mode_ff, mode_in;
   logic [s8d_pkg::CFG_W-1:0] dz_ff, dz_in;
   logic [s8d_pkg::CFG_W-1:0] wt_ff, wt_in;

   s8d_pkg::item_type   front_item, queue_item;
   s8d_pkg::result_type result;
   logic q_full, q_not_empty, q_pop, push;

   assign csr.ready = 1'b1;

   // Decode a register write; saturate the deadzone, drop unknown indexes.
   always_comb begin
      mode_in = mode_ff;
      dz_in   = dz_ff;
      wt_in   = wt_ff;
      if (csr.valid) begin
         unique case (csr.index)
            s8d_pkg::CSR_MODE: begin
               mode_in = csr.data[1:0];
            end
            s8d_pkg::CSR_DEADZONE: begin
               priority if (csr.data < s8d_pkg::DZ_MIN) dz_in = s8d_pkg::DZ_MIN;
               else if (csr.data > s8d_pkg::DZ_MAX)     dz_in = s8d_pkg::DZ_MAX;
               else                                     dz_in = csr.data;
            end
            s8d_pkg::CSR_WALK: begin
               wt_in = csr.data;
            end
            default: begin
               // no register here: drop the write
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= s8d_pkg::MODE_PASS;
         dz_ff   <= s8d_pkg::DZ_RESET;
         wt_ff   <= s8d_pkg::WT_RESET;
      end else begin
         mode_ff <= mode_in;
         dz_ff   <= dz_in;
         wt_ff   <= wt_in;
      end
   end

   // Front: clamp and classify the item as it arrives.
   s8d_front #(
      .AXIS_FULL_SCALE (AXIS_FULL_SCALE)
   ) u_front (
      .stick_x (req.stick_x),
      .stick_y (req.stick_y),
      .keys_in (req.keys_in),
      .mode    (mode_ff),
      .item    (front_item)
   );

   // Accept whenever the queue has room.
   assign req.ready = !q_full;
   assign push      = req.valid && !q_full;

   s8d_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (front_item),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_not_empty),
      .pop_item  (queue_item)
   );

   // Back: products, then the deadzone / walk / sector decision into the
   // output register.
   s8d_back u_back (
      .clock       (clock),
      .reset       (reset),
      .q_valid     (q_not_empty),
      .q_item      (queue_item),
      .q_pop       (q_pop),
      .deadzone    (dz_ff),
      .walk_thresh (wt_ff),
      .out_ready   (rsp.ready),
      .out_valid   (rsp.valid),
      .out_result  (result)
   );

   assign rsp.keys_out     = result.keys_out;
   assign rsp.in_deadzone  = result.in_deadzone;
   assign rsp.walk_skipped = result.walk_skipped;

endmodule

FILE: design/s8d_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the stick to eight-way pad block, bound to the top level.
module s8d_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic [s8d_pkg::KEYS_W-1:0] keys_out,
   input logic                       in_deadzone,
   input logic                       walk_skipped,
   input logic                       csr_valid,
   input logic                       csr_ready,
   input logic [s8d_pkg::IDX_W-1:0]  csr_index,
   input logic [s8d_pkg::CFG_W-1:0]  csr_data
);

   logic [1:0] mode_ff;
   logic       analog;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= s8d_pkg::MODE_PASS;
      end else if (csr_valid && csr_ready && csr_index == s8d_pkg::CSR_MODE) begin
         mode_ff <= csr_data[1:0];
      end
   end

   assign analog = (mode_ff == s8d_pkg::MODE_RUN) || (mode_ff == s8d_pkg::MODE_WALKRUN);

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(keys_out)
         && $stable(in_deadzone) && $stable(walk_skipped))
      else $error("stalled result changed");

   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(in_deadzone && walk_skipped))
      else $error("deadzone and walk skip both set");

   a_pass_no_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !analog |-> !in_deadzone && !walk_skipped)
      else $error("flags set in pass-through mode");

   a_sector_press: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && analog && !in_deadzone && !walk_skipped |->
         keys_out[5:4] != 2'b00 && keys_out[7:6] != 2'b00 && keys_out[7:4] != 4'hF)
      else $error("bad direction pattern for a tilted stick");

endmodule

bind stick_to_eight_way_dpad s8d_checker u_s8d_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp.valid),
   .rsp_ready    (rsp.ready),
   .keys_out     (rsp.keys_out),
   .in_deadzone  (rsp.in_deadzone),
   .walk_skipped (rsp.walk_skipped),
   .csr_valid    (csr.valid),
   .csr_ready    (csr.ready),
   .csr_index    (csr.index),
   .csr_data     (csr.data)
);

FILE: tb/sv/stick_to_eight_way_dpad_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the stick to eight-way pad block.
module stick_to_eight_way_dpad_tb;

   // codes the package leaves unnamed
   localparam logic [s8d_pkg::IDX_W-1:0] CSR_SPARE  = 2'd3;
   localparam logic [1:0]                MODE_SPARE = 2'd3;

   // half of tan(22.5 deg) in Q0.16: ay*32768 vs this*ax marks the sector edge
   localparam int TAN_HALF_Q15  = 13573;
   localparam int QUIET_LIMIT   = 2000;
   localparam int SETTLE_CYCLES = 8;
   localparam int RANDOM_PHASES = 8;
   localparam int PHASE_ITEMS   = 50;

   // Track mode, radii and walk parity; predict the key word for each sample.
   class pad_predictor;
      logic [1:0]                  cur_mode;
      logic [s8d_pkg::CFG_W-1:0]   dz_radius;
      logic [s8d_pkg::CFG_W-1:0]   walk_radius;
      bit                          odd_sample;
      s8d_pkg::result_type         pending_keys[$];
      int                          mismatches;

      function new();
         cur_mode    = s8d_pkg::MODE_PASS;
         dz_radius   = s8d_pkg::DZ_RESET;
         walk_radius = s8d_pkg::WT_RESET;
         odd_sample  = 1'b0;
         mismatches  = 0;
      endfunction

      function void write_reg(logic [s8d_pkg::IDX_W-1:0] idx,
                              logic [s8d_pkg::CFG_W-1:0] data);
         case (idx)
            s8d_pkg::CSR_MODE:     cur_mode = data[1:0];
            s8d_pkg::CSR_DEADZONE: dz_radius = (data < s8d_pkg::DZ_MIN) ? s8d_pkg::DZ_MIN :
                                               (data > s8d_pkg::DZ_MAX) ? s8d_pkg::DZ_MAX :
                                               data;
            s8d_pkg::CSR_WALK:     walk_radius = data;
            default:               ;
         endcase
      endfunction

      function void take_sample(logic signed [s8d_pkg::AXIS_W-1:0] sx,
                                logic signed [s8d_pkg::AXIS_W-1:0] sy,
                                logic [s8d_pkg::KEYS_W-1:0] keys);
         int                         x, y;
         longint unsigned            ax, ay, mag2, dz2, wt2;
         bit                         horiz, vert;
         logic [s8d_pkg::KEYS_W-1:0] press;
         s8d_pkg::result_type        r;
         x = int'(sx);
         y = int'(sy);
         if (x < -s8d_pkg::AXIS_FULL_SCALE) x = -s8d_pkg::AXIS_FULL_SCALE;
         if (y < -s8d_pkg::AXIS_FULL_SCALE) y = -s8d_pkg::AXIS_FULL_SCALE;
         ax = (x < 0) ? -x : x;
         ay = (y < 0) ? -y : y;
         mag2 = ax * ax + ay * ay;
         dz2 = longint'(dz_radius) * longint'(dz_radius);
         wt2 = longint'(walk_radius) * longint'(walk_radius);
         r.keys_out     = keys;
         r.in_deadzone  = 1'b0;
         r.walk_skipped = 1'b0;
         if (cur_mode == s8d_pkg::MODE_RUN || cur_mode == s8d_pkg::MODE_WALKRUN) begin
            if (mag2 < dz2) begin
               r.in_deadzone = 1'b1;
            end else begin
               odd_sample = ~odd_sample;
               if (cur_mode == s8d_pkg::MODE_WALKRUN && mag2 < wt2 && odd_sample) begin
                  r.walk_skipped = 1'b1;
               end else begin
                  horiz = (ay << 16) < longint'(s8d_pkg::TAN_SECTOR_Q16) * ax;
                  vert  = (ax << 16) < longint'(s8d_pkg::TAN_SECTOR_Q16) * ay;
                  press = '0;
                  if (!vert) press |= (x > 0) ? s8d_pkg::KEY_RIGHT : s8d_pkg::KEY_LEFT;
                  if (!horiz) press |= (y > 0) ? s8d_pkg::KEY_DOWN : s8d_pkg::KEY_UP;
                  r.keys_out = (keys | s8d_pkg::DIR_MASK) & ~press;
               end
            end
         end
         pending_keys.push_back(r);
      endfunction

      function void check_keys(logic [s8d_pkg::KEYS_W-1:0] keys, logic dz_flag,
                               logic skip_flag);
         s8d_pkg::result_type want;
         if (pending_keys.size() == 0) begin
            mismatches++;
            $error("unexpected result: keys_out %h", keys);
            return;
         end
         want = pending_keys.pop_front();
         if (keys !== want.keys_out) begin
            mismatches++;
            $error("keys_out: expected %h, got %h", want.keys_out, keys);
         end
         if (dz_flag !== want.in_deadzone) begin
            mismatches++;
            $error("in_deadzone: expected %b, got %b", want.in_deadzone, dz_flag);
         end
         if (skip_flag !== want.walk_skipped) begin
            mismatches++;
            $error("walk_skipped: expected %b, got %b", want.walk_skipped, skip_flag);
         end
      endfunction

      function int in_flight();
         return pending_keys.size();
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   bit   calm  = 1'b0;   // no idling on either side while set
   int   quiet_cycles = 0;

   pad_predictor pad = new();

   s8d_req_if req_ch ();
   s8d_rsp_if rsp_ch ();
   s8d_csr_if csr_ch ();

   stick_to_eight_way_dpad DUT (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch),
      .csr   (csr_ch)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Mostly no gap, often a short one, now and then a long one.
   function automatic int pick_gap();
      int r;
      if (calm) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Offer one sample after a random gap; hold it until accepted.
   // Valid stays high into the next item when there is no gap.
   task automatic push_sample(input logic signed [s8d_pkg::AXIS_W-1:0] sx,
                              input logic signed [s8d_pkg::AXIS_W-1:0] sy,
                              input logic [s8d_pkg::KEYS_W-1:0] keys);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.stick_x <= sx;
      req_ch.stick_y <= sy;
      req_ch.keys_in <= keys;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      pad.take_sample(sx, sy, keys);
   endtask

   // Drive one register write and hold until accepted; the caller drops valid.
   task automatic write_reg(input logic [s8d_pkg::IDX_W-1:0] idx,
                            input logic [s8d_pkg::CFG_W-1:0] data);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= data;
      do @(posedge clock); while (csr_ch.ready !== 1'b1);
      pad.write_reg(idx, data);
   endtask

   // Program every register, poke the spare index too, then drop valid.
   // Junk in the upper bits of the mode word must be cut away by the block.
   task automatic set_regs(input logic [1:0] mode, input logic [s8d_pkg::CFG_W-1:0] dz,
                           input logic [s8d_pkg::CFG_W-1:0] wt);
      logic [s8d_pkg::CFG_W-1:0] mode_word;
      mode_word = s8d_pkg::CFG_W'($urandom);
      mode_word[1:0] = mode;
      write_reg(s8d_pkg::CSR_MODE, mode_word);
      write_reg(s8d_pkg::CSR_DEADZONE, dz);
      write_reg(s8d_pkg::CSR_WALK, wt);
      write_reg(CSR_SPARE, s8d_pkg::CFG_W'($urandom));
      csr_ch.valid <= 1'b0;
   endtask

   // Stop offering, wait for every predicted item, then let the pipe settle.
   task automatic drain();
      req_ch.valid <= 1'b0;
      while (pad.in_flight() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Random stick position, biased toward deadzone and walk edges,
   // sector boundaries and full-scale corners.
   task automatic rand_sample(output logic signed [s8d_pkg::AXIS_W-1:0] sx,
                              output logic signed [s8d_pkg::AXIS_W-1:0] sy);
      logic [31:0] w;
      int          a, b, t;
      w = $urandom;
      a = int'(w[15:0]);
      b = int'(w[31:16]);
      case ($urandom_range(0, 5))
         0, 1: begin
            sx = w[15:0];
            sy = w[31:16];
            return;
         end
         2: begin
            a = int'(pad.dz_radius) + $urandom_range(0, 3) - 2;
            b = $urandom_range(0, 400);
         end
         3: begin
            a = int'(pad.walk_radius) + $urandom_range(0, 3) - 2;
            b = $urandom_range(0, 400);
         end
         4: begin
            a = $urandom_range(1, 32767);
            b = ((a * TAN_HALF_Q15) >> 15) + $urandom_range(0, 1);
         end
         default: begin
            a = (w[1:0] == 2'd0) ? 0 : (w[1:0] == 2'd1) ? 1 :
                (w[1:0] == 2'd2) ? 32767 : 32768;
            b = (w[3:2] == 2'd0) ? 0 : (w[3:2] == 2'd1) ? 1 :
                (w[3:2] == 2'd2) ? 32767 : 32768;
         end
      endcase
      if (a < 0) a = 0;
      if (a > 32768) a = 32767;
      if ($urandom_range(0, 1)) begin
         t = a;
         a = b;
         b = t;
      end
      if ($urandom_range(0, 1)) a = -a;
      if ($urandom_range(0, 1)) b = -b;
      sx = s8d_pkg::AXIS_W'(a);
      sy = s8d_pkg::AXIS_W'(b);
   endtask

   function automatic logic [s8d_pkg::KEYS_W-1:0] rand_keys();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return '1;
         default: return s8d_pkg::KEYS_W'($urandom);
      endcase
   endfunction

   // Sink side: release ready in random bursts, stall in random gaps.
   initial begin
      int gap;
      rsp_ch.ready = 1'b0;
      while (reset) @(posedge clock);
      forever begin
         gap = pick_gap();
         if (gap > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
   end

   // Check every accepted result against the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         pad.check_keys(rsp_ch.keys_out, rsp_ch.in_deadzone, rsp_ch.walk_skipped);
      end
   end

   // Watchdog: end the run when no handshake of any kind happens for too long.
   always @(posedge clock) begin
      if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
          (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) ||
          (csr_ch.valid === 1'b1 && csr_ch.ready === 1'b1)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      logic signed [s8d_pkg::AXIS_W-1:0] sx, sy;
      logic [1:0]                        mode_sel;
      logic [s8d_pkg::CFG_W-1:0]         dz_word, wt_word;

      req_ch.valid   = 1'b0;
      req_ch.stick_x = '0;
      req_ch.stick_y = '0;
      req_ch.keys_in = '0;
      csr_ch.valid   = 1'b0;
      csr_ch.index   = s8d_pkg::CSR_MODE;
      csr_ch.data    = '0;

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Reset settings: pass-through, so even full tilts leave keys alone.
      push_sample(16'sd32767, 16'sd32767, 16'h0000);
      push_sample(-16'sd32768, -16'sd32768, 16'hFFFF);
      push_sample(16'sd0, 16'sd0, 16'hA5A5);
      drain();

      // Run mode at the default deadzone: deadzone edge, axis and diagonal
      // extremes, the negative full-scale clamp, and both sides of the
      // horizontal and vertical sector edges.
      set_regs(s8d_pkg::MODE_RUN, s8d_pkg::DZ_RESET, s8d_pkg::WT_RESET);
      push_sample(16'sd0, 16'sd0, 16'hFFFF);
      push_sample(16'sd4914, 16'sd0, 16'h0000);
      push_sample(16'sd4915, 16'sd0, 16'h0000);
      push_sample(-16'sd32768, 16'sd0, 16'hFFFF);
      push_sample(16'sd0, -16'sd32768, 16'h00F0);
      push_sample(16'sd0, 16'sd32767, 16'hFF0F);
      push_sample(16'sd32767, 16'sd32767, 16'hFFFF);
      push_sample(-16'sd32768, -16'sd32768, 16'h0000);
      push_sample(16'sd32767, -16'sd32768, 16'h5A5A);
      push_sample(-16'sd32768, 16'sd32767, 16'hA5A5);
      push_sample(16'sd32767, 16'sd13572, 16'hFFFF);
      push_sample(16'sd32767, 16'sd13573, 16'hFFFF);
      push_sample(16'sd13572, -16'sd32768, 16'h0000);
      push_sample(16'sd13573, -16'sd32767, 16'h0000);
      drain();

      // Walk-run with a deadzone write below the floor: gentle tilts drop on
      // odd parity, a hard tilt flips parity without a drop, and a radius
      // exactly on the deadzone counts as outside.
      set_regs(s8d_pkg::MODE_WALKRUN, 15'd1000, 15'd10000);
      push_sample(16'sd5000, 16'sd0, 16'hFFFF);
      push_sample(-16'sd5000, 16'sd0, 16'hFFFF);
      push_sample(16'sd1637, 16'sd0, 16'h1234);
      push_sample(16'sd20000, 16'sd20000, 16'h0000);
      push_sample(16'sd0, 16'sd5000, 16'hFFFF);
      push_sample(-16'sd1638, 16'sd0, 16'hFFFF);
      drain();

      // Spare mode behaves as pass-through; the deadzone write saturates high.
      set_regs(MODE_SPARE, 15'd20000, 15'h7FFF);
      push_sample(16'sd32767, 16'sd0, 16'h0F0F);
      push_sample(-16'sd20000, 16'sd20000, 16'hF0F0);
      drain();

      // Random phases, each under its own settings; every fourth runs calm.
      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         calm = (ph % 4 == 3);
         case ($urandom_range(0, 9))
            0:             mode_sel = s8d_pkg::MODE_PASS;
            1:             mode_sel = MODE_SPARE;
            2, 3, 4, 5:    mode_sel = s8d_pkg::MODE_RUN;
            default:       mode_sel = s8d_pkg::MODE_WALKRUN;
         endcase
         case ($urandom_range(0, 5))
            0:       dz_word = '0;
            1:       dz_word = '1;
            2:       dz_word = s8d_pkg::DZ_MIN;
            3:       dz_word = s8d_pkg::DZ_MAX;
            default: dz_word = s8d_pkg::CFG_W'($urandom_range(0, 32767));
         endcase
         case ($urandom_range(0, 3))
            0:       wt_word = '0;
            1:       wt_word = '1;
            default: wt_word = s8d_pkg::CFG_W'($urandom_range(0, 32767));
         endcase
         set_regs(mode_sel, dz_word, wt_word);
         repeat (PHASE_ITEMS) begin
            rand_sample(sx, sy);
            push_sample(sx, sy, rand_keys());
         end
         drain();
      end

      if (pad.mismatches == 0 && pad.in_flight() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

FILE: filelist.f
design/s8d_pkg.sv
design/s8d_channels.sv
design/s8d_front.sv
design/s8d_queue.sv
design/s8d_back.sv
design/stick_to_eight_way_dpad.sv
design/s8d_checker.sv
tb/sv/stick_to_eight_way_dpad_tb.sv
